// ===== rtl/button_gesture_controller_top_defines.svh =====
// Assertion macros for the button gesture controller.
// Included by the top-level module, which checks its own logic; depends on nothing.
`ifndef BUTTON_GESTURE_CONTROLLER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BGC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("button gesture controller check failed");
`define BGC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("button gesture controller check failed");
`else
`define BGC_ASSERT(label, prop)
`define BGC_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/bgc_pkg.sv =====
// Shared constants and codes of the button gesture controller.
// Depends on nothing; used by the top level.
package bgc_pkg;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSING  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_REPEATING = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WARNING   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FIRED     = 3'd4;

    localparam logic [1:0] OUT_PENDING   = 2'd0;
    localparam logic [1:0] OUT_SUCCEEDED = 2'd1;
    localparam logic [1:0] OUT_FAILED    = 2'd2;

    localparam logic [1:0] REP_NONE        = 2'd0;
    localparam logic [1:0] REP_SAVE_FAILED = 2'd1;
    localparam logic [1:0] REP_RESET_OK    = 2'd2;
    localparam logic [1:0] REP_RESET_FAIL  = 2'd3;

    localparam logic [2:0] OV_NONE         = 3'd0;
    localparam logic [2:0] OV_SAVE_FAILED  = 3'd1;
    localparam logic [2:0] OV_WARNING      = 3'd2;
    localparam logic [2:0] OV_RESET_DONE   = 3'd3;
    localparam logic [2:0] OV_RESET_FAILED = 3'd4;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_CLICK       = 3'd1;
    localparam logic [2:0] EV_HOLD_START  = 3'd2;
    localparam logic [2:0] EV_HOLD_REPEAT = 3'd3;
    localparam logic [2:0] EV_RESET_REQ   = 3'd4;
    localparam logic [2:0] EV_RESTART_REQ = 3'd5;

    localparam logic [2:0] CFG_LONG_PRESS = 3'd0;
    localparam logic [2:0] CFG_REPEAT     = 3'd1;
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd2;
    localparam logic [2:0] CFG_WARNING    = 3'd3;
    localparam logic [2:0] CFG_FACTORY    = 3'd4;
    localparam logic [2:0] CFG_OVERLAY    = 3'd5;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [15:0] REPEAT_RESET     = 16'd200;
    localparam logic [9:0]  DEBOUNCE_RESET   = 10'd30;
    localparam logic [15:0] WARNING_RESET    = 16'd5000;
    localparam logic [15:0] FACTORY_RESET    = 16'd10000;
    localparam logic [15:0] OVERLAY_RESET    = 16'd1000;

    // Seconds rounding: ceil(x / 1000) = floor((x + 999) / 1000), the
    // division done as a multiply by round(2^26 / 1000) and a shift.
    localparam logic [16:0] MS_ROUND_UP = 17'd999;
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam int          RECIP_SHIFT = 26;

endpackage

// ===== rtl/button_gesture_controller_top.sv =====
// Button gesture controller: debounce, press phases and status per poll tick.
// Depends on bgc_pkg and button_gesture_controller_top_defines.svh.
// An accepted input word passes the input register and then the result register.
// Throughput: one word per cycle unless m_tready stalls; an input register and a
// result register hold the stream, all tick work is one combinational pass between them.
// Reset: asynchronous, active low; state clears and registers take defaults.
`include "button_gesture_controller_top_defines.svh"

module button_gesture_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], button_low[32], host_report[34:33], sink_full[35], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // gesture_event[2:0], overlay[5:3], countdown_s[12:6], zero fill
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] long_press_reg, repeat_reg, warning_reg, factory_reg, overlay_ms_reg;
    logic [9:0]  debounce_reg;

    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic        in_pin_reg;
    logic [1:0]  in_rep_reg;
    logic        in_full_reg;

    logic        out_valid_reg;
    logic [2:0]  out_ev_reg, out_ov_reg;
    logic [6:0]  out_cd_reg;

    logic        raw_reg, stable_reg;
    logic [31:0] changed_at_reg, press_start_reg, next_repeat_reg, overlay_start_reg;
    logic [2:0]  phase_reg, overlay_reg;
    logic [15:0] latched_reg;
    logic [1:0]  outcome_reg;

    logic        raw_next, stable_next;
    logic [31:0] changed_at_next, press_start_next, next_repeat_next, overlay_start_next;
    logic [2:0]  phase_next, overlay_next, ev_next, ov_next, pick;
    logic [15:0] latched_next;
    logic [1:0]  outcome_next;
    logic [6:0]  cd_next;

    logic [1:0]  outcome_rep;
    logic [2:0]  overlay_rep, overlay_exp;
    logic [31:0] held_old, repeat_diff;
    logic [16:0] cd_num;
    logic [33:0] cd_prod;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_cd_reg, out_ov_reg, out_ev_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= bgc_pkg::LONG_PRESS_RESET;
            repeat_reg     <= bgc_pkg::REPEAT_RESET;
            debounce_reg   <= bgc_pkg::DEBOUNCE_RESET;
            warning_reg    <= bgc_pkg::WARNING_RESET;
            factory_reg    <= bgc_pkg::FACTORY_RESET;
            overlay_ms_reg <= bgc_pkg::OVERLAY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bgc_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                bgc_pkg::CFG_REPEAT:     repeat_reg     <= cfg_data;
                bgc_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data[9:0];
                bgc_pkg::CFG_WARNING:    warning_reg    <= cfg_data;
                bgc_pkg::CFG_FACTORY:    factory_reg    <= cfg_data;
                bgc_pkg::CFG_OVERLAY:    overlay_ms_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_now_reg  <= s_tdata[31:0];
            in_pin_reg  <= s_tdata[32];
            in_rep_reg  <= s_tdata[34:33];
            in_full_reg <= s_tdata[35];
        end
    end

    always_comb
    begin
        outcome_rep        = outcome_reg;
        overlay_rep        = overlay_reg;
        overlay_start_next = overlay_start_reg;
        unique case (in_rep_reg)
            bgc_pkg::REP_NONE:
            begin
            end
            bgc_pkg::REP_SAVE_FAILED:
            begin
                overlay_start_next = in_now_reg;
                overlay_rep        = bgc_pkg::OV_SAVE_FAILED;
            end
            bgc_pkg::REP_RESET_OK:
            begin
                overlay_start_next = in_now_reg;
                outcome_rep        = bgc_pkg::OUT_SUCCEEDED;
                overlay_rep        = bgc_pkg::OV_RESET_DONE;
            end
            default:
            begin
                overlay_start_next = in_now_reg;
                outcome_rep        = bgc_pkg::OUT_FAILED;
                overlay_rep        = bgc_pkg::OV_RESET_FAILED;
            end
        endcase

        overlay_exp = overlay_rep;
        if (overlay_rep == bgc_pkg::OV_SAVE_FAILED &&
            (in_now_reg - overlay_start_next) >= {16'd0, overlay_ms_reg})
        begin
            overlay_exp = bgc_pkg::OV_NONE;
        end

        raw_next        = in_pin_reg;
        changed_at_next = (in_pin_reg != raw_reg) ? in_now_reg : changed_at_reg;
        stable_next     = stable_reg;
        if (raw_next != stable_reg &&
            (in_now_reg - changed_at_next) >= {22'd0, debounce_reg})
        begin
            stable_next = raw_next;
        end

        held_old    = in_now_reg - press_start_reg;
        repeat_diff = in_now_reg - next_repeat_reg;
        priority if (held_old >= {16'd0, factory_reg})
            pick = bgc_pkg::PH_FIRED;
        else if (held_old >= {16'd0, warning_reg})
            pick = bgc_pkg::PH_WARNING;
        else if (held_old >= {16'd0, latched_reg})
            pick = bgc_pkg::PH_REPEATING;
        else
            pick = bgc_pkg::PH_PRESSING;

        phase_next       = phase_reg;
        press_start_next = press_start_reg;
        latched_next     = latched_reg;
        outcome_next     = outcome_rep;
        next_repeat_next = next_repeat_reg;
        overlay_next     = overlay_exp;
        ev_next          = bgc_pkg::EV_NONE;

        if (!(phase_reg == bgc_pkg::PH_FIRED && outcome_rep == bgc_pkg::OUT_PENDING))
        begin
            if (!stable_next)
            begin
                if (phase_reg != bgc_pkg::PH_IDLE)
                begin
                    phase_next = bgc_pkg::PH_IDLE;
                    if (overlay_exp == bgc_pkg::OV_RESET_DONE ||
                        overlay_exp == bgc_pkg::OV_RESET_FAILED)
                    begin
                        overlay_next = bgc_pkg::OV_NONE;
                    end
                    if (phase_reg == bgc_pkg::PH_PRESSING && !in_full_reg)
                    begin
                        ev_next = bgc_pkg::EV_CLICK;
                    end
                    else if (phase_reg == bgc_pkg::PH_FIRED &&
                             outcome_rep == bgc_pkg::OUT_SUCCEEDED && !in_full_reg)
                    begin
                        ev_next = bgc_pkg::EV_RESTART_REQ;
                    end
                end
            end
            else if (phase_reg == bgc_pkg::PH_IDLE)
            begin
                phase_next       = bgc_pkg::PH_PRESSING;
                press_start_next = in_now_reg;
                outcome_next     = bgc_pkg::OUT_PENDING;
                latched_next     = long_press_reg;
            end
            else if (pick != phase_reg)
            begin
                phase_next = pick;
                if (pick == bgc_pkg::PH_REPEATING)
                begin
                    ev_next          = in_full_reg ? bgc_pkg::EV_NONE : bgc_pkg::EV_HOLD_START;
                    next_repeat_next = in_now_reg + {16'd0, repeat_reg};
                end
                else if (pick == bgc_pkg::PH_FIRED)
                begin
                    ev_next = in_full_reg ? bgc_pkg::EV_NONE : bgc_pkg::EV_RESET_REQ;
                    if (in_full_reg)
                    begin
                        outcome_next = bgc_pkg::OUT_FAILED;
                    end
                end
            end
            else if (phase_reg == bgc_pkg::PH_REPEATING && !repeat_diff[31])
            begin
                ev_next          = in_full_reg ? bgc_pkg::EV_NONE : bgc_pkg::EV_HOLD_REPEAT;
                next_repeat_next = in_now_reg + {16'd0, repeat_reg};
            end
        end

        // The warning phase is never entered from idle, so the press start is unchanged.
        cd_num  = {1'b0, factory_reg - held_old[15:0]} + bgc_pkg::MS_ROUND_UP;
        cd_prod = cd_num * bgc_pkg::RECIP_1000;
        cd_next = 7'd0;
        if (phase_next == bgc_pkg::PH_WARNING)
        begin
            ov_next = bgc_pkg::OV_WARNING;
            if (held_old < {16'd0, factory_reg})
            begin
                cd_next = cd_prod[bgc_pkg::RECIP_SHIFT +: 7];
            end
        end
        else
        begin
            ov_next = overlay_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg           <= 1'b0;
            stable_reg        <= 1'b0;
            changed_at_reg    <= 32'd0;
            phase_reg         <= bgc_pkg::PH_IDLE;
            press_start_reg   <= 32'd0;
            latched_reg       <= 16'd0;
            outcome_reg       <= bgc_pkg::OUT_PENDING;
            next_repeat_reg   <= 32'd0;
            overlay_reg       <= bgc_pkg::OV_NONE;
            overlay_start_reg <= 32'd0;
        end
        else if (advance)
        begin
            raw_reg           <= raw_next;
            stable_reg        <= stable_next;
            changed_at_reg    <= changed_at_next;
            phase_reg         <= phase_next;
            press_start_reg   <= press_start_next;
            latched_reg       <= latched_next;
            outcome_reg       <= outcome_next;
            next_repeat_reg   <= next_repeat_next;
            overlay_reg       <= overlay_next;
            overlay_start_reg <= overlay_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ev_reg <= ev_next;
            out_ov_reg <= ov_next;
            out_cd_reg <= cd_next;
        end
    end

    `BGC_ASSERT(a_cd_only_in_warning,
        (out_valid_reg && out_cd_reg != 7'd0) |-> (out_ov_reg == bgc_pkg::OV_WARNING))
    `BGC_ASSERT(a_cd_range, out_valid_reg |-> (out_cd_reg <= 7'd66))
    `BGC_ASSERT(a_fired_holds,
        (advance && phase_reg == bgc_pkg::PH_FIRED && outcome_reg == bgc_pkg::OUT_PENDING &&
         in_rep_reg == bgc_pkg::REP_NONE) |=> (phase_reg == bgc_pkg::PH_FIRED))
    `BGC_ASSERT(a_held_item_kept, (in_valid_reg && !advance) |=> in_valid_reg)
    `BGC_ASSERT(a_ready_when_out_free, !out_valid_reg |-> s_tready)
    `BGC_ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready)

endmodule
